/* sv/rfr_pkg.sv */
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants of the radio fragment reassembler.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int MSG_DEPTH_DEF   = 512;
  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int MIN_PAYLOAD     = 2;

  localparam int POS_W  = 5;
  localparam int SIZE_W = 6;
  localparam int LEN_W  = 8;

  localparam logic [SIZE_W-1:0] FRAG_SIZE_RST = 6'd32;

  // register index taken from paddr[2]
  localparam logic REG_FRAG_SIZE = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0] msg_length;
    logic             last;
    logic [3:0]       bytes;
    logic [63:0]      data;
  } rfr_beat_t;

endpackage

/* sv/rfr_cmd_queue.sv */
// ----------------------------------------------------------------------------
// rfr_cmd_queue
// Two-entry queue of delivery jobs between intake and delivery.
// ----------------------------------------------------------------------------
module rfr_cmd_queue #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/rfr_front.sv */
// ----------------------------------------------------------------------------
// rfr_front
// Byte intake: store writes, sequence check and delivery decision.
// ----------------------------------------------------------------------------
module rfr_front #(
  parameter int MSG_DEPTH   = rfr_pkg::MSG_DEPTH_DEF,
  parameter int MAX_PAYLOAD = rfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rfr_pkg::SIZE_W-1:0]        frag_size,
  input  logic                              rx_valid,
  output logic                              byte_ready,
  input  logic [7:0]                        rx_byte,
  output logic                              wr_en,
  output logic [$clog2(MSG_DEPTH)-1:0]      wr_addr,
  output logic [7:0]                        wr_data,
  output logic                              cmd_push,
  output logic [rfr_pkg::LEN_W+$clog2(MSG_DEPTH+1)-1:0] cmd_data,
  input  logic                              q_empty,
  input  logic                              q_full
);

  localparam int AW  = $clog2(MSG_DEPTH);
  localparam int WCW = $clog2(MSG_DEPTH + 1);
  localparam logic [WCW-1:0] DEPTH_W = WCW'(MSG_DEPTH);
  localparam logic [rfr_pkg::SIZE_W-1:0] MAXP = rfr_pkg::SIZE_W'(MAX_PAYLOAD);
  localparam logic [rfr_pkg::SIZE_W-1:0] MINP = rfr_pkg::SIZE_W'(rfr_pkg::MIN_PAYLOAD);

  logic [WCW-1:0]               write_count;
  logic [WCW-1:0]               high_mark;
  logic [rfr_pkg::POS_W-1:0]    byte_position;
  logic [7:0]                   last_seq;
  logic [rfr_pkg::LEN_W-1:0]    len_byte;

  logic [rfr_pkg::SIZE_W-1:0]   eff_size;
  logic                         is_data;
  logic                         accept;
  logic                         seq_match;
  logic [WCW-1:0]               wc_mid;
  logic                         emit;

  always_comb begin
    if (frag_size < MINP) begin
      eff_size = MINP;
    end else if (frag_size > MAXP) begin
      eff_size = MAXP;
    end else begin
      eff_size = frag_size;
    end
  end

  assign is_data    = ({1'b0, byte_position} + 6'd1) < eff_size;
  assign byte_ready = is_data ? q_empty : !q_full;
  assign accept     = rx_valid && byte_ready;
  assign seq_match  = ({1'b0, rx_byte} == ({1'b0, last_seq} + 9'd1));
  assign wc_mid     = seq_match ? write_count : '0;
  assign emit       = (wc_mid >= WCW'(len_byte));

  assign wr_en    = accept && is_data && (write_count < DEPTH_W);
  assign wr_addr  = write_count[AW-1:0];
  assign wr_data  = rx_byte;
  assign cmd_push = accept && !is_data && emit && (len_byte != '0);
  assign cmd_data = {len_byte, high_mark};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count   <= '0;
      high_mark     <= '0;
      byte_position <= '0;
      last_seq      <= '0;
      len_byte      <= '0;
    end else if (accept) begin
      if (is_data) begin
        byte_position <= byte_position + 5'd1;
        if (write_count < DEPTH_W) begin
          write_count <= write_count + WCW'(1);
          if (write_count == high_mark) begin
            high_mark <= write_count + WCW'(1);
          end
          if (write_count == WCW'(1)) begin
            len_byte <= rx_byte;
          end
        end
      end else begin
        byte_position <= '0;
        if (emit) begin
          write_count <= '0;
          last_seq    <= '0;
        end else begin
          write_count <= wc_mid;
          last_seq    <= seq_match ? rx_byte : 8'd0;
        end
      end
    end
  end

endmodule

/* sv/rfr_back.sv */
// ----------------------------------------------------------------------------
// rfr_back
// Message store and delivery: reads 8-byte rows and forms output beats.
// ----------------------------------------------------------------------------
module rfr_back #(
  parameter int MSG_DEPTH = rfr_pkg::MSG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MSG_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         cmd_valid,
  input  logic [rfr_pkg::LEN_W+$clog2(MSG_DEPTH+1)-1:0] cmd_data,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rfr_pkg::rfr_beat_t           out_beat
);

  localparam int AW   = $clog2(MSG_DEPTH);
  localparam int WCW  = $clog2(MSG_DEPTH + 1);
  localparam int RAW  = AW - 3;
  localparam int ROWS = (MSG_DEPTH + 7) / 8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t     state;
  state_t     state_next;

  logic [63:0] mem [ROWS];
  logic [63:0] rd_data;
  logic [4:0]  row;

  logic [rfr_pkg::LEN_W-1:0] len;
  logic [WCW-1:0]            high_mark;
  logic [7:0]                base;
  logic [7:0]                rem;
  logic                      beat_last;
  logic [3:0]                beat_bytes;
  logic [63:0]               beat_data;
  logic                      load;
  rfr_pkg::rfr_beat_t        beat;

  assign len       = cmd_data[rfr_pkg::LEN_W+WCW-1:WCW];
  assign high_mark = cmd_data[WCW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:3]][{wr_addr[2:0], 3'b000} +: 8] <= wr_data;
    end
    if (state == S_READ) begin
      rd_data <= mem[RAW'(row)];
    end
  end

  assign base       = {row, 3'b000};
  assign rem        = len - base;
  assign beat_last  = (rem <= 8'd8);
  assign beat_bytes = beat_last ? rem[3:0] : 4'd8;

  always_comb begin
    logic [8:0] idx;
    for (int k = 0; k < 8; k++) begin
      idx = {1'b0, base} + 9'(k);
      if ((4'(k) < beat_bytes) && (WCW'(idx) < high_mark)) begin
        beat_data[8*k +: 8] = rd_data[8*k +: 8];
      end else begin
        beat_data[8*k +: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    beat.msg_length = len;
    beat.last       = beat_last;
    beat.bytes      = beat_bytes;
    beat.data       = beat_data;
  end

  assign load    = (state == S_LOAD) && (!out_valid || out_ready);
  assign cmd_pop = load && beat_last;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (load) begin
          state_next = beat_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        row <= '0;
      end else if (load) begin
        row <= row + 5'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat <= beat;
    end
  end

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> cmd_valid)
    else $error("delivery running without a queued job");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOAD) && !$past(state == S_LOAD)) |-> $past(state == S_READ))
    else $error("beat formed without a row read");

  a_beat_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_beat.bytes != 4'd0) && (out_beat.bytes <= 4'd8)))
    else $error("beat byte count out of range");

endmodule

/* sv/radio_fragment_reassembler.sv */
// ----------------------------------------------------------------------------
// radio_fragment_reassembler
// Rebuilds a message from sequenced radio payloads and delivers it in beats.
// ----------------------------------------------------------------------------
// Input stream (s_*): one payload byte per transaction. A payload is
// frag_size bytes, held to 2..MAX_PAYLOAD; the last is the sequence number.
// Output stream (m_*): one beat per transaction, up to 8 message bytes,
// m_tlast on the final beat of a message.
// Config: APB register 0 (address 0) is frag_size, 6 bits, reset 32.
// Flow: while a message is queued or being delivered, data bytes stall;
// sequence bytes are held only when the job queue is full. Each beat is a
// row read of the message store, then a beat load into the output register.
// Reset clears all control state. Unwritten store bytes read as zero via a
// high-water mark, so no clearing pass is needed after reset.
// A stalled m_tready holds the current beat; intake of the next message
// resumes once the last beat is in the output register.
// ----------------------------------------------------------------------------
module radio_fragment_reassembler #(
  parameter int MSG_DEPTH   = rfr_pkg::MSG_DEPTH_DEF,
  parameter int MAX_PAYLOAD = rfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [63:0] out_data, [67:64] out_bytes, [75:68] msg_length
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(MSG_DEPTH);
  localparam int WCW = $clog2(MSG_DEPTH + 1);
  localparam int CW  = rfr_pkg::LEN_W + WCW;

  logic [rfr_pkg::SIZE_W-1:0] frag_size;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          cmd_push;
  logic [CW-1:0] cmd_data;
  logic [CW-1:0] cmd_head;
  logic          cmd_pop;
  logic          q_empty;
  logic          q_full;

  rfr_pkg::rfr_beat_t out_beat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_size <= rfr_pkg::FRAG_SIZE_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rfr_pkg::REG_FRAG_SIZE)) begin
      frag_size <= pwdata[rfr_pkg::SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == rfr_pkg::REG_FRAG_SIZE) ?
                  {26'd0, frag_size} : 32'd0;

  rfr_front #(
    .MSG_DEPTH   (MSG_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frag_size    (frag_size),
    .rx_valid     (s_tvalid),
    .byte_ready   (s_tready),
    .rx_byte      (s_tdata),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_data),
    .q_empty      (q_empty),
    .q_full       (q_full)
  );

  rfr_cmd_queue #(
    .W (CW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_data),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rfr_back #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cmd_valid (!q_empty),
    .cmd_data  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_beat  (out_beat)
  );

  assign m_tdata = {4'd0, out_beat.msg_length, out_beat.bytes, out_beat.data};
  assign m_tlast = out_beat.last;

endmodule

/* dv/tb_radio_fragment_reassembler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radio_fragment_reassembler
// Feeds sequenced radio payload bytes into the reassembler under several
// payload sizes. Well-formed messages, broken sequences and loose noise are
// mixed. A scoreboard rebuilds each message from the accepted bytes and
// checks every delivered beat field by field. Both stream sides idle at
// random, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_radio_fragment_reassembler;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;  // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // [63:0] out_data, [67:64] out_bytes, [75:68] msg_length
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  radio_fragment_reassembler u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // scoreboard copy of the block state
  logic [7:0] msg_mem [rfr_pkg::MSG_DEPTH_DEF];
  int         wr_cnt   = 0;
  int         frag_pos = 0;
  int         seq_prev = 0;
  logic [5:0] cfg_size = rfr_pkg::FRAG_SIZE_RST;

  rfr_pkg::rfr_beat_t beat_expect [$];
  logic [7:0]         rx_pending  [$];
  rfr_pkg::rfr_beat_t want;

  int   gen_pos      = 0;
  int   bytes_queued = 0;
  bit   idle_en      = 1'b1;
  logic stall_req    = 1'b0;
  logic stall_req_q  = 1'b0;
  int   src_gap      = 0;
  int   sink_gap     = 0;
  int   hold_left    = 0;
  int   mismatches   = 0;
  int   cycles       = 0;

  function automatic int eff_size(input logic [5:0] s);
    if (s < rfr_pkg::MIN_PAYLOAD) return rfr_pkg::MIN_PAYLOAD;
    if (s > rfr_pkg::MAX_PAYLOAD_DEF) return rfr_pkg::MAX_PAYLOAD_DEF;
    return int'(s);
  endfunction

  task automatic reassemble_byte(input logic [7:0] b);
    int len, cnt, p, k, nb;
    rfr_pkg::rfr_beat_t beat;
    if (frag_pos + 1 < eff_size(cfg_size)) begin
      if (wr_cnt < rfr_pkg::MSG_DEPTH_DEF) begin
        msg_mem[wr_cnt] = b;
        wr_cnt++;
      end
      frag_pos++;
    end else begin
      frag_pos = 0;
      if (int'(b) == seq_prev + 1) begin
        seq_prev = b;
      end else begin
        wr_cnt   = 0;
        seq_prev = 0;
      end
      len = msg_mem[1];
      if (wr_cnt >= len) begin
        wr_cnt   = 0;
        seq_prev = 0;
        nb       = 0;
        for (p = 0; p < len && nb < 32; p += 8) begin
          cnt  = (len - p > 8) ? 8 : len - p;
          beat = '0;
          for (k = 0; k < cnt; k++) beat.data[8*k +: 8] = msg_mem[p + k];
          beat.bytes      = 4'(cnt);
          beat.last       = (p + cnt >= len);
          beat.msg_length = 8'(len);
          beat_expect.push_back(beat);
          nb++;
        end
      end
    end
  endtask

  // byte source: tracks the payload position the block will see
  task automatic push_rx(input logic [7:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
    if (gen_pos + 1 < eff_size(cfg_size)) gen_pos++;
    else gen_pos = 0;
  endtask

  task automatic push_packed(input logic [71:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) push_rx(v[8*i +: 8]);
  endtask

  task automatic queue_message(input int len, input bit broken);
    int dpp, npl, pl, k, bad_pl;
    bit cut;
    logic [7:0] b;
    while (gen_pos != 0) push_rx(8'($urandom_range(0, 255)));
    dpp    = eff_size(cfg_size) - 1;
    npl    = ((len < 2 ? 2 : len) + dpp - 1) / dpp;
    bad_pl = broken ? $urandom_range(1, npl) : 0;
    cut    = 1'($urandom_range(0, 1));
    for (pl = 1; pl <= npl; pl++) begin
      for (k = 0; k < dpp; k++) begin
        b = ((pl - 1) * dpp + k == 1) ? 8'(len) : 8'($urandom_range(0, 255));
        push_rx(b);
        if (pl == bad_pl && cut && k == dpp / 2) return;
      end
      push_rx(pl == bad_pl ? 8'(pl + $urandom_range(1, 255)) : 8'(pl));
    end
  endtask

  task automatic queue_group();
    int r, len, cap;
    r   = $urandom_range(0, 99);
    cap = 8 * (eff_size(cfg_size) - 1);
    if (r < 15) begin
      repeat ($urandom_range(1, 12)) push_rx(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 19))
        0:          len = $urandom_range(0, 1);
        1, 2, 3:    len = $urandom_range(25, 80);
        4:          len = $urandom_range(81, 128);
        default:    len = $urandom_range(2, 24);
      endcase
      if (len > cap) len = cap;
      queue_message(len, r < 30);
    end
  endtask

  task automatic write_frag_size(input logic [5:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rfr_pkg::REG_FRAG_SIZE, 2'b00};
    pwdata  <= {26'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_size = v;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (rx_pending.size() != 0 || s_tvalid || beat_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) reassemble_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          s_tdata  <= rx_pending.pop_front();
          s_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 16);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (beat_expect.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected beat: data=%h bytes=%0d last=%0b len=%0d",
                     m_tdata[63:0], m_tdata[67:64], m_tlast, m_tdata[75:68]);
          mismatches++;
        end else begin
          want = beat_expect.pop_front();
          if (m_tdata[63:0] !== want.data || m_tdata[67:64] !== want.bytes ||
              m_tlast !== want.last || m_tdata[75:68] !== want.msg_length) begin
            if (mismatches < 10) begin
              $display("beat mismatch: exp data=%h bytes=%0d last=%0b len=%0d",
                       want.data, want.bytes, want.last, want.msg_length);
              $display("               got data=%h bytes=%0d last=%0b len=%0d",
                       m_tdata[63:0], m_tdata[67:64], m_tlast, m_tdata[75:68]);
            end
            mismatches++;
          end
        end
      end
      stall_req_q <= stall_req;
      if (stall_req && !stall_req_q) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int ph, sz, n0;
    foreach (msg_mem[i]) msg_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // length byte still zero from reset: payload end clears, nothing delivered
    write_frag_size(6'd1);
    push_packed(72'h01_FF, 2);
    wait_idle();

    // one full 8-byte beat
    write_frag_size(6'd9);
    push_packed(72'h01_03_02_01_7F_80_FF_08_00, 9);
    push_packed(72'h33_22_11, 3);
    wait_idle();

    // size shrinks mid-payload, next byte is a wrong sequence number
    write_frag_size(6'd4);
    push_packed(72'hFF, 1);
    push_packed(72'h01_BB_03_AA, 4);
    wait_idle();

    // explicit zero length
    write_frag_size(6'd3);
    push_packed(72'h01_00_00, 3);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       sz = 63;
        1:       sz = 32;
        2:       sz = 0;
        3:       sz = 33;
        4:       sz = 2;
        default: sz = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 31)
                                                  : $urandom_range(3, 12);
      endcase
      write_frag_size(6'(sz));
      if (ph == 1) queue_message(62, 1'b0);
      if (ph == 5) stall_req <= 1'b1;
      n0 = bytes_queued;
      while (bytes_queued - n0 < 16) queue_group();
      wait_idle();
    end

    idle_en = 1'b0;
    write_frag_size(6'($urandom_range(3, 31)));
    n0 = bytes_queued;
    while (bytes_queued - n0 < 12) queue_group();
    wait_idle();

    if (mismatches == 0 && beat_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
